FILE: src/wma_pkg.sv
// shared types, constants and helpers of the water meter accounting engine
package wma_pkg;

  localparam int LOG_DAYS_DEF = 30;

  localparam int CMD_W = 3;
  localparam int DAY_W = 5;
  localparam int MON_W = 4;
  localparam int IDX_W = 5;
  localparam int REG_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W = 32;
  localparam int COST_W = 48;
  localparam int NUM_W = 42;
  localparam int DEN_W = 32;
  localparam int IN_TDATA_W = 24;
  localparam int OUT_TDATA_W = 320;

  localparam logic [CMD_W-1:0] CMD_PULSE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_TICK = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SAVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RST_SESSION = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RST_TODAY = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FACTORY = 3'd5;
  localparam logic [CMD_W-1:0] CMD_READ_LOG = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_PPL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COST = 2'd2;

  localparam logic [REG_W-1:0] PPL_RST = 16'd450;
  localparam logic [REG_W-1:0] WINDOW_RST = 16'd1000;
  localparam logic [REG_W-1:0] COST_RST = 16'd50;

  localparam logic [25:0] ML_MIN_SCALE = 26'd60000000;
  localparam logic [9:0] ML_PER_L = 10'd1000;

  typedef struct packed {
    logic latch;
    logic exec;
    logic flow_load;
    logic flow_fin;
    logic save_load;
    logic save_fin;
    logic calc_load;
    logic calc_fin;
    logic div_start;
    logic out_load;
  } wma_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic close_win;
    logic div_done;
  } wma_stat_t;

  function automatic logic [CNT_W-1:0] sat_add32(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_q(input logic [NUM_W-1:0] q);
    return (|q[NUM_W-1:CNT_W]) ? {CNT_W{1'b1}} : q[CNT_W-1:0];
  endfunction

endpackage

FILE: src/wma_div.sv
// restoring divider, one quotient bit per cycle
module wma_div import wma_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient,
  output logic [DEN_W-1:0] remainder
);
  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [DEN_W-1:0]  dvs;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;

  assign trial = {remainder, quotient[NUM_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(NUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      if (!diff[DEN_W]) begin
        remainder <= diff[DEN_W-1:0];
        quotient  <= {quotient[NUM_W-2:0], 1'b1};
      end else begin
        remainder <= trial[DEN_W-1:0];
        quotient  <= {quotient[NUM_W-2:0], 1'b0};
      end
    end
  end
endmodule

FILE: src/wma_ctrl.sv
// sequencer of the accounting engine
module wma_ctrl import wma_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  input  wma_stat_t stat,
  output wma_cmd_t  ctl
);
  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_EXEC      = 4'd1;
  localparam logic [3:0] ST_FLOW_LD   = 4'd2;
  localparam logic [3:0] ST_FLOW_GO   = 4'd3;
  localparam logic [3:0] ST_FLOW_WAIT = 4'd4;
  localparam logic [3:0] ST_SAVE_LD   = 4'd5;
  localparam logic [3:0] ST_SAVE_GO   = 4'd6;
  localparam logic [3:0] ST_SAVE_WAIT = 4'd7;
  localparam logic [3:0] ST_CALC_LD   = 4'd8;
  localparam logic [3:0] ST_CALC_GO   = 4'd9;
  localparam logic [3:0] ST_CALC_WAIT = 4'd10;
  localparam logic [3:0] ST_OUT       = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    ctl = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          ctl.latch = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl.exec = 1'b1;
        if (stat.cmd == CMD_TICK && stat.close_win) state_next = ST_FLOW_LD;
        else if (stat.cmd == CMD_SAVE) state_next = ST_SAVE_LD;
        else state_next = ST_CALC_LD;
      end
      ST_FLOW_LD: begin
        ctl.flow_load = 1'b1;
        state_next = ST_FLOW_GO;
      end
      ST_FLOW_GO: begin
        ctl.div_start = 1'b1;
        state_next = ST_FLOW_WAIT;
      end
      ST_FLOW_WAIT: begin
        if (stat.div_done) begin
          ctl.flow_fin = 1'b1;
          state_next = ST_CALC_LD;
        end
      end
      ST_SAVE_LD: begin
        ctl.save_load = 1'b1;
        state_next = ST_SAVE_GO;
      end
      ST_SAVE_GO: begin
        ctl.div_start = 1'b1;
        state_next = ST_SAVE_WAIT;
      end
      ST_SAVE_WAIT: begin
        if (stat.div_done) begin
          ctl.save_fin = 1'b1;
          state_next = ST_CALC_LD;
        end
      end
      ST_CALC_LD: begin
        ctl.calc_load = 1'b1;
        state_next = ST_CALC_GO;
      end
      ST_CALC_GO: begin
        ctl.div_start = 1'b1;
        state_next = ST_CALC_WAIT;
      end
      ST_CALC_WAIT: begin
        if (stat.div_done) begin
          ctl.calc_fin = 1'b1;
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          ctl.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end
endmodule

FILE: src/wma_dpath.sv
// counters, daily log, multipliers and shared divider
module wma_dpath import wma_pkg::*; #(
  parameter int LOG_DAYS = LOG_DAYS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [REG_W-1:0]       cfg_data,
  input  wma_cmd_t               ctl,
  output wma_stat_t              stat,
  output logic [OUT_TDATA_W-1:0] m_tdata
);
  localparam int LW = (LOG_DAYS > 1) ? $clog2(LOG_DAYS) : 1;

  logic [REG_W-1:0] ppl, win_len, cost;
  logic [CMD_W-1:0] cmd;
  logic [DAY_W-1:0] day, last_day;
  logic [MON_W-1:0] month, last_month;
  logic [IDX_W-1:0] log_idx;

  logic [REG_W-1:0] win_pulses, win_elapsed, elapsed_inc, eff_ppl, eff_len;
  logic [CNT_W-1:0] flow_rate, session, today, month_cnt, prev_month, total;
  logic [CNT_W-1:0] session_ml, log_val, today_add;
  logic [COST_W-1:0] today_cost, month_cost;

  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  logic             div_done;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] rem;

  logic [CNT_W-1:0] mem [LOG_DAYS];
  logic [LOG_DAYS-1:0] log_valid;
  logic [LW-1:0]    slot_tab [32];
  logic [LW-1:0]    slot;
  logic             log_wr;
  logic             idx_ok;
  logic [CNT_W-1:0] rd_data;
  logic             rd_ok;

  wma_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (num),
    .divisor  (den),
    .done     (div_done),
    .quotient (quo),
    .remainder(rem)
  );

  assign eff_ppl     = (ppl == '0) ? REG_W'(1) : ppl;
  assign eff_len     = (win_len == '0) ? REG_W'(1) : win_len;
  assign elapsed_inc = (&win_elapsed) ? win_elapsed : win_elapsed + 1'b1;
  assign today_add   = sat_add32(today, quo[CNT_W-1:0]);

  assign stat.cmd       = cmd;
  assign stat.close_win = (elapsed_inc >= eff_len);
  assign stat.div_done  = div_done;

  // ring slot for the day that just ended
  always_comb begin
    for (int i = 0; i < 32; i++) begin
      slot_tab[i] = LW'((i + LOG_DAYS - 1) % LOG_DAYS);
    end
  end
  assign slot   = slot_tab[last_day];
  assign log_wr = ctl.save_fin && (day != last_day);
  assign idx_ok = ({27'd0, log_idx} < LOG_DAYS);

  always_ff @(posedge clk) begin
    if (rst) begin
      ppl     <= PPL_RST;
      win_len <= WINDOW_RST;
      cost    <= COST_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PPL:    ppl <= cfg_data;
        REG_WINDOW: win_len <= cfg_data;
        REG_COST:   cost <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd     <= s_tdata[2:0];
      day     <= s_tdata[7:3];
      month   <= s_tdata[11:8];
      log_idx <= s_tdata[16:12];
    end
  end

  always_ff @(posedge clk) begin
    if (log_wr) mem[slot] <= today_add;
    if (ctl.exec) rd_data <= mem[log_idx[LW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_pulses  <= '0;
      win_elapsed <= '0;
      flow_rate   <= '0;
      session     <= '0;
      today       <= '0;
      month_cnt   <= '0;
      prev_month  <= '0;
      total       <= '0;
      last_day    <= DAY_W'(1);
      last_month  <= MON_W'(1);
      log_valid   <= '0;
      rd_ok       <= 1'b0;
    end else begin
      if (ctl.exec) begin
        rd_ok <= (cmd == CMD_READ_LOG) && idx_ok && log_valid[log_idx[LW-1:0]];
        case (cmd)
          CMD_PULSE: if (!(&win_pulses)) win_pulses <= win_pulses + 1'b1;
          CMD_TICK: win_elapsed <= elapsed_inc;
          CMD_RST_SESSION: session <= '0;
          CMD_RST_TODAY: today <= '0;
          CMD_FACTORY: begin
            total      <= '0;
            month_cnt  <= '0;
            prev_month <= '0;
            today      <= '0;
            last_day   <= day;
            last_month <= month;
            log_valid  <= '0;
          end
          default: ;
        endcase
      end
      if (ctl.flow_fin) begin
        flow_rate   <= sat_q(quo);
        session     <= sat_add32(session, {16'd0, win_pulses});
        win_pulses  <= '0;
        win_elapsed <= '0;
      end
      if (ctl.save_fin) begin
        session <= rem;
        total   <= sat_add32(total, quo[CNT_W-1:0]);
        if (day != last_day) begin
          today          <= '0;
          last_day       <= day;
          log_valid[slot] <= 1'b1;
        end else begin
          today <= today_add;
        end
        if (month != last_month) begin
          prev_month <= sat_add32(month_cnt, quo[CNT_W-1:0]);
          month_cnt  <= '0;
          last_month <= month;
        end else begin
          month_cnt <= sat_add32(month_cnt, quo[CNT_W-1:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.flow_load) begin
      num <= NUM_W'(win_pulses * ML_MIN_SCALE);
      den <= DEN_W'(eff_ppl * win_elapsed);
    end else if (ctl.save_load) begin
      num <= NUM_W'(session);
      den <= DEN_W'(eff_ppl);
    end else if (ctl.calc_load) begin
      num <= NUM_W'(session * ML_PER_L);
      den <= DEN_W'(eff_ppl);
    end
    if (ctl.calc_load) begin
      today_cost <= COST_W'(today * cost);
      month_cost <= COST_W'(month_cnt * cost);
      log_val    <= rd_ok ? rd_data : '0;
    end
    if (ctl.calc_fin) session_ml <= sat_q(quo);
    if (ctl.out_load) begin
      m_tdata <= {log_val, month_cost, today_cost, total, prev_month, month_cnt,
                  today, session_ml, flow_rate};
    end
  end
endmodule

FILE: src/water_meter_accounting_top.sv
// top level of the water meter accounting engine
//
//  port group    dir   beat contents
//  s_*           in    one command item per beat
//  m_*           out   one report of all counters per beat
//  cfg_*         in    register write, index 0 pulses/litre, 1 window, 2 cost
//
// an item runs exec, the calc divider pass and the output load; a save or a tick
// that closes a window runs a save or flow divider pass first; a new item is taken
// only once the last report is loaded; each divider pass is 42 radix-2 steps
// plus load, start and finish, and every item runs one for session_ml
// reset is synchronous; all counters clear, day and month memory go to one,
// the daily log reads zero until written (valid bits, no clearing sweep)
// the finished report sits in the output register so the next item is
// taken while it waits; a stalled output only holds the last step of an item
module water_meter_accounting_top import wma_pkg::*; #(
  parameter int LOG_DAYS = LOG_DAYS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // cmd[2:0], day[7:3], month[11:8], log_index[16:12], zero fill
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // flow_rate_ml_per_min[31:0], session_ml[63:32], today_liters[95:64],
  // month_liters[127:96], previous_month_liters[159:128], total_liters[191:160],
  // today_cost_milli[239:192], month_cost_milli[287:240], log_liters[319:288]
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [REG_W-1:0]       cfg_data
);
  wma_cmd_t  ctl;
  wma_stat_t stat;

  // sequencer
  wma_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .stat    (stat),
    .ctl     (ctl)
  );

  // counters, log and arithmetic
  wma_dpath #(.LOG_DAYS(LOG_DAYS)) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .ctl      (ctl),
    .stat     (stat),
    .m_tdata  (m_tdata)
  );
endmodule

FILE: sim/tb_water_meter_accounting_top.sv
// testbench for the water meter accounting engine: directed and random command streams against a model
`timescale 1ns / 100ps

module tb_water_meter_accounting_top;
  import wma_pkg::*;

  localparam int NDAYS = LOG_DAYS_DEF;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [MON_W-1:0] month;
    logic [DAY_W-1:0] day;
    logic [CMD_W-1:0] cmd;
  } meter_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]  log_l;
    logic [COST_W-1:0] month_cost;
    logic [COST_W-1:0] today_cost;
    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  prev_month;
    logic [CNT_W-1:0]  month_l;
    logic [CNT_W-1:0]  today;
    logic [CNT_W-1:0]  session_ml;
    logic [CNT_W-1:0]  flow;
  } meter_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;

  water_meter_accounting_top dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow of the meter state
  logic [15:0] m_ppl, m_win, m_cost;
  logic [15:0] w_pulses, w_ms;
  logic [31:0] flow_r, sess_p, today_c, month_c, prev_c, total_c;
  logic [4:0]  last_day;
  logic [3:0]  last_mon;
  logic [31:0] day_log [NDAYS];

  meter_item_t   pending_items[$];
  meter_report_t expected_reports[$];
  int errors = 0;
  int accepted = 0;
  int hold_off = 0;

  function automatic logic [31:0] sat32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
    return sat32({32'd0, a} + {32'd0, b});
  endfunction

  task automatic meter_reset();
    m_ppl = PPL_RST; m_win = WINDOW_RST; m_cost = COST_RST;
    w_pulses = 0; w_ms = 0; flow_r = 0; sess_p = 0;
    today_c = 0; month_c = 0; prev_c = 0; total_c = 0;
    last_day = 1; last_mon = 1;
    foreach (day_log[i]) day_log[i] = 0;
  endtask

  // advance the shadow state by one item and queue its report
  task automatic predict_report(input meter_item_t it);
    logic [63:0] ppl, num, den;
    logic [31:0] lit, logv;
    meter_report_t r;
    ppl = (m_ppl == 0) ? 64'd1 : {48'd0, m_ppl};
    logv = 0;
    case (it.cmd)
      CMD_PULSE: if (w_pulses != 16'hFFFF) w_pulses++;
      CMD_TICK: begin
        if (w_ms != 16'hFFFF) w_ms++;
        if (w_ms >= ((m_win == 0) ? 16'd1 : m_win)) begin
          num = w_pulses * 64'd60000000;
          den = ppl * w_ms;
          if (den == 0) den = 1;
          flow_r = sat32(num / den);
          sess_p = add_sat(sess_p, {16'd0, w_pulses});
          w_pulses = 0; w_ms = 0;
        end
      end
      CMD_SAVE: begin
        lit = sess_p / ppl[31:0];
        sess_p = sess_p - lit * ppl[31:0];
        total_c = add_sat(total_c, lit);
        month_c = add_sat(month_c, lit);
        today_c = add_sat(today_c, lit);
        if (it.day != last_day) begin
          day_log[(last_day + NDAYS - 1) % NDAYS] = today_c;
          today_c = 0;
          last_day = it.day;
        end
        if (it.month != last_mon) begin
          prev_c = month_c; month_c = 0; last_mon = it.month;
        end
      end
      CMD_RST_SESSION: sess_p = 0;
      CMD_RST_TODAY: today_c = 0;
      CMD_FACTORY: begin
        total_c = 0; month_c = 0; prev_c = 0; today_c = 0;
        last_day = it.day; last_mon = it.month;
        foreach (day_log[i]) day_log[i] = 0;
      end
      CMD_READ_LOG: if (it.idx < NDAYS) logv = day_log[it.idx];
      default: ;
    endcase
    r.flow = flow_r;
    r.session_ml = sat32(({32'd0, sess_p} * 64'd1000) / ppl);
    r.today = today_c; r.month_l = month_c; r.prev_month = prev_c; r.total = total_c;
    r.today_cost = today_c * m_cost;
    r.month_cost = month_c * m_cost;
    r.log_l = logv;
    expected_reports.push_back(r);
  endtask

  // sender: bursts and gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_report(meter_item_t'(s_tdata[16:0]));
        accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata <= {7'd0, pending_items.pop_front()};
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) gap_left = $urandom_range(0, 150);
          end else begin
            burst_left--;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: own stall pattern plus a long hold-off
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      stall_phase++;
      if (hold_off > 0) begin
        hold_off--;
        m_tready <= 1'b0;
      end else if (stall_phase % 700 < 250) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  // monitor: compare each report beat with the oldest prediction
  always @(posedge clk) begin
    meter_report_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_reports.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected report beat %h", m_tdata);
      end else begin
        want = expected_reports.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("report mismatch\n  exp %h\n  got %h", want, got);
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || s_tvalid || expected_reports.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PPL: m_ppl = val;
      REG_WINDOW: m_win = val;
      REG_COST: m_cost = val;
      default: ;
    endcase
  endtask

  function automatic meter_item_t mk(input logic [2:0] c, input logic [4:0] d,
                                     input logic [3:0] mo, input logic [4:0] ix);
    meter_item_t it;
    it.cmd = c; it.day = d; it.month = mo; it.idx = ix;
    return it;
  endfunction

  // random item, weighted toward pulses and ticks, realistic calendar mostly
  function automatic meter_item_t rand_item(input int dayset);
    int p;
    logic [2:0] c;
    p = $urandom_range(0, 99);
    if (p < 45) c = CMD_PULSE;
    else if (p < 75) c = CMD_TICK;
    else if (p < 85) c = CMD_SAVE;
    else if (p < 95) c = CMD_READ_LOG;
    else c = 3'($urandom_range(3, 7));
    if ($urandom_range(0, 9) == 0)
      return mk(c, 5'($urandom), 4'($urandom), 5'($urandom));
    return mk(c, 5'(dayset % 31 + 1), 4'(dayset / 8 % 12 + 1), 5'($urandom_range(0, 29)));
  endfunction

  initial begin
    int dayset;
    meter_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: small window and ppl so windows close and litres appear
    write_reg(REG_PPL, 16'd3);
    write_reg(REG_WINDOW, 16'd2);
    write_reg(REG_COST, 16'hFFFF);
    repeat (6) pending_items.push_back(mk(CMD_PULSE, 1, 1, 0));
    pending_items.push_back(mk(CMD_TICK, 1, 1, 0));
    pending_items.push_back(mk(CMD_TICK, 1, 1, 0));
    pending_items.push_back(mk(CMD_SAVE, 1, 1, 0));
    pending_items.push_back(mk(CMD_SAVE, 5'd31, 4'd15, 0));
    pending_items.push_back(mk(CMD_SAVE, 5'd0, 4'd0, 0));
    pending_items.push_back(mk(CMD_READ_LOG, 1, 1, 5'd0));
    pending_items.push_back(mk(CMD_READ_LOG, 1, 1, 5'd29));
    pending_items.push_back(mk(CMD_READ_LOG, 1, 1, 5'd31));
    pending_items.push_back(mk(CMD_RST_SESSION, 1, 1, 0));
    pending_items.push_back(mk(CMD_RST_TODAY, 1, 1, 0));
    pending_items.push_back(mk(3'd7, 5'd31, 4'd15, 5'd31));
    pending_items.push_back(mk(CMD_FACTORY, 5'd0, 4'd9, 0));
    pending_items.push_back(mk(CMD_SAVE, 5'd3, 4'd9, 0));
    pending_items.push_back(mk(CMD_READ_LOG, 1, 1, 5'd29));
    wait_drained();

    // zero ppl and window registers are treated as one; a zero cost stays zero
    write_reg(REG_PPL, 16'd0);
    write_reg(REG_WINDOW, 16'd0);
    write_reg(REG_COST, 16'd0);
    for (int i = 0; i < 300; i++) pending_items.push_back(rand_item(i / 20));
    wait_drained();

    // long receiver hold-off while the sender keeps offering
    write_reg(REG_PPL, 16'd1);
    write_reg(REG_WINDOW, 16'd3);
    write_reg(REG_COST, 16'd777);
    hold_off = 3000;
    for (int i = 0; i < 400; i++) pending_items.push_back(rand_item(i / 10));
    wait_drained();

    write_reg(REG_PPL, 16'hFFFF);
    write_reg(REG_WINDOW, 16'hFFFF);
    write_reg(REG_COST, 16'd1);
    for (int i = 0; i < 150; i++) pending_items.push_back(rand_item(i / 30));
    wait_drained();

    // reset values for ppl and cost, window of 5
    write_reg(REG_PPL, PPL_RST);
    write_reg(REG_WINDOW, 16'd5);
    write_reg(REG_COST, COST_RST);
    dayset = 0;
    for (int i = 0; i < 720; i++) begin
      if (i % 24 == 0) dayset = $urandom_range(0, 400);
      pending_items.push_back(rand_item(dayset));
    end
    wait_drained();

    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #40ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: filelist.f
src/wma_pkg.sv
src/wma_div.sv
src/wma_ctrl.sv
src/wma_dpath.sv
src/water_meter_accounting_top.sv
sim/tb_water_meter_accounting_top.sv
